### hw/rtl/led_pattern_transition_controller_unit_defines.svh
// Assertion macros for the LED pattern transition controller checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef LED_PATTERN_TRANSITION_CONTROLLER_UNIT_DEFINES_SVH
`define LED_PATTERN_TRANSITION_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LPTC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/lptc_pkg.sv
// Shared types and constants of the LED pattern transition controller.
// No dependencies.
package lptc_pkg;

  localparam int unsigned PATTERN_COUNT_DEF = 32;

  localparam int unsigned PAT_W  = 8;
  localparam int unsigned LEN_W  = 14;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned CHK_W  = 14;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned PROG_W = 8;
  localparam int unsigned DIV_W  = LEN_W + PROG_W;
  localparam int unsigned STEP_W = 3;

  localparam logic [LEN_W-1:0]  LEN_RESET       = 14'd1000;
  localparam logic [LEN_W-1:0]  LEN_MIN         = 14'd100;
  localparam logic [LEN_W-1:0]  LEN_MAX         = 14'd10000;
  localparam logic [TIME_W-1:0] RATE_LIMIT_MS   = 16'd200;
  localparam logic [TIME_W-1:0] CHECK_PERIOD_MS = 16'd10000;
  localparam logic [TIME_W-1:0] STUCK_GRACE_MS  = 16'd5000;
  localparam logic [PROG_W-1:0] FLASH_POINT     = 8'd128;
  localparam logic [PROG_W-1:0] FULL_SCALE      = 8'd255;
  localparam logic [PAT_W-1:0]  SAFE_PATTERN    = 8'd16;

  localparam logic [2:0] MODE_TICK = 3'd0;
  localparam logic [2:0] MODE_SET  = 3'd1;
  localparam logic [2:0] MODE_NEXT = 3'd2;
  localparam logic [2:0] MODE_PREV = 3'd3;
  localparam logic [2:0] MODE_SAFE = 3'd4;

  localparam logic [1:0] KIND_IMMEDIATE = 2'd0;
  localparam logic [1:0] KIND_FADE      = 2'd1;
  localparam logic [1:0] KIND_WIPE      = 2'd2;
  localparam logic [1:0] KIND_FLASH     = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_SAME    = 2'd2;
  localparam logic [1:0] STAT_BLOCKED = 2'd3;

  localparam logic REG_TRANS_LEN = 1'b0;
  localparam logic REG_CHECKS_EN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_POST,
    ST_CHECK,
    ST_DONE
  } lptc_state_e;

endpackage

### hw/rtl/lptc_if.sv
// Handshake channels of the LED pattern transition controller.
// Depends on lptc_pkg.
interface lptc_req_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  mode;
  logic [lptc_pkg::PAT_W-1:0]  pattern_index;
  logic [1:0]                  transition_kind;
  logic                        render_busy;
  modport source (output valid, mode, pattern_index, transition_kind, render_busy,
                  input ready);
  modport sink   (input valid, mode, pattern_index, transition_kind, render_busy,
                  output ready);
endinterface

interface lptc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [lptc_pkg::PAT_W-1:0]  active_pattern;
  logic [lptc_pkg::PAT_W-1:0]  destination_pattern;
  logic                        in_transition;
  logic [lptc_pkg::PROG_W-1:0] progress;
  logic [lptc_pkg::CNT_W-1:0]  changes_total;
  modport source (output valid, status, active_pattern, destination_pattern,
                  in_transition, progress, changes_total, input ready);
  modport sink   (input valid, status, active_pattern, destination_pattern,
                  in_transition, progress, changes_total, output ready);
endinterface

interface lptc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic                        index;
  logic [lptc_pkg::LEN_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/led_pattern_transition_controller_unit.sv
// LED pattern transition controller, top level.
// Depends on lptc_pkg and the channel interfaces in lptc_if.sv.
//
// Keeps the active LED pattern and serves one request at a time: a 1 ms tick,
// set, next, previous or safe set, each answered by exactly one response with
// status, active and destination pattern, transition flag, progress and the
// count of completed changes. A change request passes from idle through the
// done state, which registers its response; a tick passes through the check
// state before done, and while a timed transition runs and does not end on
// that tick it first passes through the divide and post states, since
// progress = elapsed * 255 / length is formed by a compare-and-subtract unit
// that settles one quotient bit per cycle, eight quotient bits in all.
// req_i.ready is high only while the sequencer is idle; the
// response register holds a finished result while the next request is taken,
// and a full response register that stays unread holds the sequencer in its
// done state and so delays the next request.
// Configuration writes are always ready; the transition length is clamped to
// 100..10000 ms on write.
module led_pattern_transition_controller_unit #(
  parameter int unsigned PATTERN_COUNT = lptc_pkg::PATTERN_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lptc_req_if.sink   req_i,
  lptc_rsp_if.source rsp_o,
  lptc_cfg_if.sink   cfg_i
);

  localparam logic [lptc_pkg::PAT_W-1:0] PAT_CNT = lptc_pkg::PAT_W'(PATTERN_COUNT);

  lptc_pkg::lptc_state_e state_q, state_d;

  logic [lptc_pkg::PAT_W-1:0]  cur_q, cur_d, tgt_q, tgt_d;
  logic                        busy_q, busy_d, pend_q, pend_d;
  logic [1:0]                  kind_q, kind_d;
  logic [lptc_pkg::PROG_W-1:0] prog_q, prog_d;
  logic [lptc_pkg::TIME_W-1:0] elapsed_q, elapsed_d, since_q, since_d;
  logic [lptc_pkg::CHK_W-1:0]  chk_q, chk_d;
  logic [lptc_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [lptc_pkg::LEN_W-1:0]  len_q, len_d;
  logic                        chken_q, chken_d;
  logic [1:0]                  status_q, status_d;

  // Divider working registers.
  logic [lptc_pkg::DIV_W-1:0]  rem_q, rem_d;
  logic [lptc_pkg::PROG_W-1:0] quo_q, quo_d;
  logic [lptc_pkg::STEP_W-1:0] step_q, step_d;

  // Response register.
  logic                        out_valid_q, out_valid_d;
  logic [1:0]                  out_status_q, out_status_d;
  logic [lptc_pkg::PAT_W-1:0]  out_active_q, out_active_d, out_dest_q, out_dest_d;
  logic                        out_trans_q, out_trans_d;
  logic [lptc_pkg::PROG_W-1:0] out_prog_q, out_prog_d;
  logic [lptc_pkg::CNT_W-1:0]  out_cnt_q, out_cnt_d;

  logic req_fire, rsp_fire, cfg_fire;

  assign req_i.ready = (state_q == lptc_pkg::ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_fire    = rsp_o.valid && rsp_o.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  assign rsp_o.valid               = out_valid_q;
  assign rsp_o.status              = out_status_q;
  assign rsp_o.active_pattern      = out_active_q;
  assign rsp_o.destination_pattern = out_dest_q;
  assign rsp_o.in_transition       = out_trans_q;
  assign rsp_o.progress            = out_prog_q;
  assign rsp_o.changes_total       = out_cnt_q;

  // Configuration: clamp the length into its legal window.
  always_comb begin
    len_d   = len_q;
    chken_d = chken_q;
    if (cfg_fire) begin
      case (cfg_i.index)
        lptc_pkg::REG_TRANS_LEN: begin
          if (cfg_i.data < lptc_pkg::LEN_MIN) begin
            len_d = lptc_pkg::LEN_MIN;
          end else if (cfg_i.data > lptc_pkg::LEN_MAX) begin
            len_d = lptc_pkg::LEN_MAX;
          end else begin
            len_d = cfg_i.data;
          end
        end
        lptc_pkg::REG_CHECKS_EN: chken_d = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Request decode: the pattern a request names and its transition kind.
  logic [lptc_pkg::PAT_W-1:0] next_pat, req_idx;
  logic [1:0]                 req_kind;
  logic                       req_is_change;

  always_comb begin
    next_pat = cur_q + 8'd1;
    if (next_pat >= PAT_CNT) begin
      next_pat = 8'd1;
    end
    req_idx       = req_i.pattern_index;
    req_kind      = req_i.transition_kind;
    req_is_change = 1'b1;
    case (req_i.mode)
      lptc_pkg::MODE_SET: ;
      lptc_pkg::MODE_NEXT: begin
        req_idx  = next_pat;
        req_kind = lptc_pkg::KIND_FADE;
      end
      lptc_pkg::MODE_PREV: begin
        req_idx  = (cur_q <= 8'd1) ? (PAT_CNT - 8'd1) : (cur_q - 8'd1);
        req_kind = lptc_pkg::KIND_FADE;
      end
      lptc_pkg::MODE_SAFE: req_kind = lptc_pkg::KIND_IMMEDIATE;
      default: req_is_change = 1'b0;
    endcase
  end

  // Tick counters, saturating.
  logic [lptc_pkg::TIME_W-1:0] elapsed_inc, since_inc;
  logic [lptc_pkg::CHK_W-1:0]  chk_inc;
  logic [lptc_pkg::DIV_W-1:0]  dividend;

  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 16'd1;
  assign since_inc   = (since_q == '1) ? since_q : since_q + 16'd1;
  assign chk_inc     = (chk_q == '1) ? chk_q : chk_q + 14'd1;
  // Only used while elapsed is below the length, so 14 bits hold it.
  assign dividend    = lptc_pkg::DIV_W'(elapsed_inc[lptc_pkg::LEN_W-1:0])
                       * lptc_pkg::DIV_W'(lptc_pkg::FULL_SCALE);

  // Compare-and-subtract unit: length shifted to the current quotient bit.
  logic [lptc_pkg::DIV_W-1:0] div_sub;
  logic                       div_ge;

  assign div_sub = lptc_pkg::DIV_W'(len_q) << step_q;
  assign div_ge  = (rem_q >= div_sub);

  // Stuck-state check working values.
  logic [lptc_pkg::PAT_W-1:0]  v_cur;
  logic                        v_busy, v_pend;
  logic [lptc_pkg::PROG_W-1:0] v_prog;
  logic [lptc_pkg::TIME_W-1:0] v_since;
  logic [lptc_pkg::CNT_W-1:0]  v_cnt;
  logic [lptc_pkg::TIME_W-1:0] stuck_limit;

  assign stuck_limit = lptc_pkg::TIME_W'(len_q) + lptc_pkg::STUCK_GRACE_MS;

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    tgt_d     = tgt_q;
    busy_d    = busy_q;
    pend_d    = pend_q;
    kind_d    = kind_q;
    prog_d    = prog_q;
    elapsed_d = elapsed_q;
    since_d   = since_q;
    chk_d     = chk_q;
    cnt_d     = cnt_q;
    status_d  = status_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    step_d    = step_q;

    v_cur   = cur_q;
    v_busy  = busy_q;
    v_pend  = pend_q;
    v_prog  = prog_q;
    v_since = since_q;
    v_cnt   = cnt_q;

    out_valid_d  = out_valid_q && !rsp_fire;
    out_status_d = out_status_q;
    out_active_d = out_active_q;
    out_dest_d   = out_dest_q;
    out_trans_d  = out_trans_q;
    out_prog_d   = out_prog_q;
    out_cnt_d    = out_cnt_q;

    case (state_q)
      lptc_pkg::ST_IDLE: begin
        if (req_fire) begin
          status_d = lptc_pkg::STAT_OK;
          state_d  = lptc_pkg::ST_DONE;
          if (req_i.mode == lptc_pkg::MODE_TICK) begin
            // Advance counters, then finish or start the progress divide.
            elapsed_d = elapsed_inc;
            since_d   = since_inc;
            chk_d     = chk_inc;
            state_d   = lptc_pkg::ST_CHECK;
            if (busy_q) begin
              if (elapsed_inc >= lptc_pkg::TIME_W'(len_q)) begin
                cur_d   = tgt_q;
                busy_d  = 1'b0;
                pend_d  = 1'b0;
                prog_d  = '0;
                since_d = '0;
                cnt_d   = cnt_q + 32'd1;
              end else begin
                rem_d   = dividend;
                quo_d   = '0;
                step_d  = '1;
                state_d = lptc_pkg::ST_DIV;
              end
            end
          end else if (req_is_change) begin
            if (req_idx >= PAT_CNT) begin
              status_d = lptc_pkg::STAT_INVALID;
            end else if (req_i.mode == lptc_pkg::MODE_SAFE && req_i.render_busy) begin
              status_d = lptc_pkg::STAT_BLOCKED;
            end else if (req_idx == cur_q && !busy_q) begin
              status_d = lptc_pkg::STAT_SAME;
            end else if (pend_q || since_q < lptc_pkg::RATE_LIMIT_MS) begin
              status_d = lptc_pkg::STAT_BLOCKED;
            end else if (req_kind == lptc_pkg::KIND_IMMEDIATE) begin
              cur_d   = req_idx;
              since_d = '0;
              cnt_d   = cnt_q + 32'd1;
            end else begin
              tgt_d     = req_idx;
              kind_d    = req_kind;
              busy_d    = 1'b1;
              pend_d    = 1'b1;
              elapsed_d = '0;
              prog_d    = '0;
            end
          end
        end
      end

      lptc_pkg::ST_DIV: begin
        // Settle one quotient bit per cycle, most significant first.
        if (div_ge) begin
          rem_d         = rem_q - div_sub;
          quo_d[step_q] = 1'b1;
        end
        step_d = step_q - 3'd1;
        if (step_q == '0) begin
          state_d = lptc_pkg::ST_POST;
        end
      end

      lptc_pkg::ST_POST: begin
        prog_d = quo_q;
        if (kind_q == lptc_pkg::KIND_FLASH) begin
          if (quo_q >= lptc_pkg::FLASH_POINT && cur_q != tgt_q) begin
            cur_d = tgt_q;
          end
        end else if (kind_q == lptc_pkg::KIND_IMMEDIATE) begin
          cur_d  = tgt_q;
          busy_d = 1'b0;
          pend_d = 1'b0;
        end
        state_d = lptc_pkg::ST_CHECK;
      end

      lptc_pkg::ST_CHECK: begin
        if (chken_q && lptc_pkg::TIME_W'(chk_q) > lptc_pkg::CHECK_PERIOD_MS) begin
          chk_d = '0;
          if (v_cur >= PAT_CNT) begin
            v_cur = lptc_pkg::SAFE_PATTERN;
          end
          if (v_busy && elapsed_q > stuck_limit) begin
            v_cur   = tgt_q;
            v_busy  = 1'b0;
            v_pend  = 1'b0;
            v_prog  = '0;
            v_since = '0;
            v_cnt   = cnt_q + 32'd1;
          end
          if (v_pend && v_since > lptc_pkg::CHECK_PERIOD_MS) begin
            v_pend = 1'b0;
          end
          cur_d   = v_cur;
          busy_d  = v_busy;
          pend_d  = v_pend;
          prog_d  = v_prog;
          since_d = v_since;
          cnt_d   = v_cnt;
        end
        state_d = lptc_pkg::ST_DONE;
      end

      lptc_pkg::ST_DONE: begin
        // Hold until the response register is free, then publish.
        if (!out_valid_q || rsp_fire) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_active_d = cur_q;
          out_dest_d   = tgt_q;
          out_trans_d  = busy_q;
          out_prog_d   = prog_q;
          out_cnt_d    = cnt_q;
          state_d      = lptc_pkg::ST_IDLE;
        end
      end

      default: state_d = lptc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lptc_pkg::ST_IDLE;
      cur_q       <= lptc_pkg::SAFE_PATTERN;
      tgt_q       <= '0;
      busy_q      <= 1'b0;
      pend_q      <= 1'b0;
      kind_q      <= lptc_pkg::KIND_FADE;
      prog_q      <= '0;
      elapsed_q   <= '0;
      since_q     <= '0;
      chk_q       <= '0;
      cnt_q       <= '0;
      len_q       <= lptc_pkg::LEN_RESET;
      chken_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      tgt_q       <= tgt_d;
      busy_q      <= busy_d;
      pend_q      <= pend_d;
      kind_q      <= kind_d;
      prog_q      <= prog_d;
      elapsed_q   <= elapsed_d;
      since_q     <= since_d;
      chk_q       <= chk_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      chken_q     <= chken_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers, no reset needed.
  always_ff @(posedge clk_i) begin
    status_q     <= status_d;
    rem_q        <= rem_d;
    quo_q        <= quo_d;
    step_q       <= step_d;
    out_status_q <= out_status_d;
    out_active_q <= out_active_d;
    out_dest_q   <= out_dest_d;
    out_trans_q  <= out_trans_d;
    out_prog_q   <= out_prog_d;
    out_cnt_q    <= out_cnt_d;
  end

endmodule

### hw/rtl/lptc_checker.sv
// Port-level checks of the LED pattern transition controller, bound to the top.
// Depends on lptc_pkg and led_pattern_transition_controller_unit_defines.svh.
`include "led_pattern_transition_controller_unit_defines.svh"

module lptc_checker #(
  parameter int unsigned PATTERN_COUNT = lptc_pkg::PATTERN_COUNT_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic [lptc_pkg::PAT_W-1:0]  rsp_active_i,
  input logic                        rsp_trans_i,
  input logic [lptc_pkg::PROG_W-1:0] rsp_progress_i
);

  localparam logic [lptc_pkg::PAT_W-1:0] PAT_CNT = lptc_pkg::PAT_W'(PATTERN_COUNT);

  // A stalled response stays up with the same pattern.
  `LPTC_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_active_i), "response dropped or changed while stalled")
  // One request at a time: no second acceptance right after one.
  `LPTC_ASSERT_NEXT(a_one_at_a_time, req_valid_i && req_ready_i, !req_ready_i, "request taken while previous one still in work")
  // The shown pattern is always a legal one.
  `LPTC_ASSERT_SAME(a_active_legal, rsp_valid_i, rsp_active_i < PAT_CNT, "active pattern out of range")
  // Progress reads zero when no transition runs.
  `LPTC_ASSERT_SAME(a_idle_progress, rsp_valid_i && !rsp_trans_i, rsp_progress_i == '0, "progress nonzero outside a transition")

endmodule

bind led_pattern_transition_controller_unit lptc_checker #(
  .PATTERN_COUNT(PATTERN_COUNT)
) u_lptc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_active_i  (rsp_o.active_pattern),
  .rsp_trans_i   (rsp_o.in_transition),
  .rsp_progress_i(rsp_o.progress)
);
